// ===== hw/rtl/ialu_pkg.sv =====
package ialu_pkg;

	// operand width of the datapath
	localparam int DATA_WIDTH = 32;

	// operation codes of the opcode register
	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_MOD  = 4'd4,
		OP_MAX  = 4'd5,
		OP_MIN  = 4'd6,
		OP_CSGN = 4'd7,
		OP_POW  = 4'd8,
		OP_AND  = 4'd9,
		OP_OR   = 4'd10,
		OP_XOR  = 4'd11,
		OP_SHL  = 4'd12,
		OP_SHR  = 4'd13,
		OP_SAR  = 4'd14,
		OP_NONE = 4'd15
	} opcode_t;

	// broadcast modes
	typedef enum logic [1:0] {
		BC_NONE    = 2'd0,
		BC_SCALAR  = 2'd1,
		BC_REVERSE = 2'd2,
		BC_SPARE   = 2'd3
	} bcast_t;

	// register indexes of the configuration port
	localparam logic [1:0] REG_OPCODE = 2'd0;
	localparam logic [1:0] REG_BCAST  = 2'd1;
	localparam logic [1:0] REG_SCALAR = 2'd2;

	// input transaction
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] a_value;
		logic signed [DATA_WIDTH-1:0] b_value;
		logic                         last_in;
	} ialu_in_t;

	// output transaction
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result_value;
		logic                         divide_by_zero;
		logic                         last_out;
	} ialu_out_t;

endpackage

// ===== hw/rtl/int32_elementwise_binary_alu.sv =====
// Streaming 32-bit integer ALU: one operation per operand pair.
// Input channel in_valid / in_stall / in_data carries a_value, b_value and
// last_in; output channel out_valid / out_stall / out_data carries
// result_value, divide_by_zero and last_out. A transaction moves at a rising
// edge where valid is high and stall is low.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata):
// index 0 opcode, 1 broadcast mode, 2 scalar operand; other indexes ignored.
// Write it only while the pipeline is empty.
// Throughput is one transaction per cycle while out_stall does not hold a
// waiting result. The depth is set by the divider and the power unit, which
// retire one quotient bit and one exponent bit per pipeline stage.
// Reset (arst_n low) empties the pipeline and clears all registers to zero
// (opcode add, no broadcast, scalar 0).
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
module int32_elementwise_binary_alu (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  ialu_pkg::ialu_in_t     in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ialu_pkg::ialu_out_t    out_data,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [ialu_pkg::DATA_WIDTH-1:0] cfg_wdata
);
	import ialu_pkg::*;

	localparam int W = DATA_WIDTH;

	typedef struct packed {
		logic         valid;
		opcode_t      op;
		logic         last;
		logic [W-1:0] x;
		logic [W-1:0] y;
	} front_t;

	typedef struct packed {
		logic         valid;
		opcode_t      op;
		logic         last;
		logic         xneg;
		logic         yneg;
		logic         dz;
		logic [W-1:0] ub;
		logic [W-1:0] rem;
		logic [W-1:0] dq;
		logic [W-1:0] expo;
		logic [W-1:0] acc;
		logic [W-1:0] base;
		logic [W-1:0] simple;
	} iter_t;

	// configuration registers
	opcode_t      opcode_q;
	bcast_t       bcast_q;
	logic [W-1:0] scalar_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q <= OP_ADD;
			bcast_q  <= BC_NONE;
			scalar_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OPCODE: opcode_q <= opcode_t'(cfg_wdata[3:0]);
				REG_BCAST:  bcast_q  <= bcast_t'(cfg_wdata[1:0]);
				REG_SCALAR: scalar_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// global advance: pipeline moves unless a waiting result is stalled
	logic advance;
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// stage 1: operand selection
	front_t front_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1 <= '0;
		end else if (advance) begin
			front_s1.valid <= in_valid;
			front_s1.op    <= opcode_q;
			front_s1.last  <= in_data.last_in;
			case (bcast_q)
				BC_SCALAR: begin
					front_s1.x <= in_data.a_value;
					front_s1.y <= scalar_q;
				end
				BC_REVERSE: begin
					front_s1.x <= scalar_q;
					front_s1.y <= in_data.a_value;
				end
				default: begin
					front_s1.x <= in_data.a_value;
					front_s1.y <= in_data.b_value;
				end
			endcase
		end
	end

	// stage 2: simple operations and setup of divider and power unit
	iter_t st_s [0:W];
	iter_t setup;

	always_comb begin
		logic [W-1:0]          x;
		logic [W-1:0]          y;
		logic [$clog2(W)-1:0]  sh;
		logic                  xneg;
		logic                  yneg;
		logic [W-1:0]          xabs;
		logic [W-1:0]          xnegated;
		x        = front_s1.x;
		y        = front_s1.y;
		sh       = y[$clog2(W)-1:0];
		xneg     = x[W-1];
		yneg     = y[W-1];
		xnegated = W'(~x + 1'b1);
		xabs     = xneg ? xnegated : x;

		setup.valid = front_s1.valid;
		setup.op    = front_s1.op;
		setup.last  = front_s1.last;
		setup.xneg  = xneg;
		setup.yneg  = yneg;
		setup.dz    = (front_s1.op == OP_DIV || front_s1.op == OP_MOD) && (y == '0);
		setup.ub    = yneg ? W'(~y + 1'b1) : y;
		setup.rem   = '0;
		setup.dq    = xabs;
		setup.expo  = y;
		setup.acc   = W'(1);
		setup.base  = x;

		case (front_s1.op)
			OP_ADD:  setup.simple = W'(x + y);
			OP_SUB:  setup.simple = W'(x - y);
			OP_MUL:  setup.simple = W'(x * y);
			OP_MAX:  setup.simple = ($signed(x) > $signed(y)) ? x : y;
			OP_MIN:  setup.simple = ($signed(x) < $signed(y)) ? x : y;
			OP_CSGN: setup.simple = (xneg ^ yneg) ? xnegated : x;
			OP_AND:  setup.simple = x & y;
			OP_OR:   setup.simple = x | y;
			OP_XOR:  setup.simple = x ^ y;
			OP_SHL:  setup.simple = x << sh;
			OP_SHR:  setup.simple = x >> sh;
			OP_SAR:  setup.simple = W'($signed(x) >>> sh);
			default: setup.simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s[0] <= '0;
		end else if (advance) begin
			st_s[0] <= setup;
		end
	end

	// iteration stages: one quotient bit and one exponent bit each
	for (genvar k = 0; k < W; k++) begin : g_iter
		iter_t nxt;

		always_comb begin
			logic [W:0] t;
			logic [W:0] diff;
			logic       ge;
			t    = {st_s[k].rem, st_s[k].dq[W-1]};
			diff = t - {1'b0, st_s[k].ub};
			ge   = (t >= {1'b0, st_s[k].ub});
			nxt      = st_s[k];
			nxt.rem  = ge ? diff[W-1:0] : t[W-1:0];
			nxt.dq   = {st_s[k].dq[W-2:0], ge};
			nxt.acc  = st_s[k].expo[k] ? W'(st_s[k].acc * st_s[k].base) : st_s[k].acc;
			nxt.base = W'(st_s[k].base * st_s[k].base);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_s[k+1] <= '0;
			end else if (advance) begin
				st_s[k+1] <= nxt;
			end
		end
	end

	// final stage: euclidean correction and result selection
	iter_t      fin;
	ialu_out_t  res;

	assign fin = st_s[W];

	always_comb begin
		logic         fix;
		logic [W-1:0] qsel;
		logic [W-1:0] quo;
		logic [W-1:0] rmd;
		fix  = fin.xneg && (fin.rem != '0);
		qsel = fix ? W'(fin.dq + 1'b1) : fin.dq;
		quo  = (fin.xneg ^ fin.yneg) ? W'(~qsel + 1'b1) : qsel;
		rmd  = fix ? W'(fin.ub - fin.rem) : fin.rem;

		res.divide_by_zero = fin.dz;
		res.last_out       = fin.last;
		if (fin.dz) begin
			res.result_value = '0;
		end else begin
			case (fin.op)
				OP_DIV:  res.result_value = quo;
				OP_MOD:  res.result_value = rmd;
				OP_POW:  res.result_value = fin.yneg ? '0 : fin.acc;
				default: res.result_value = fin.simple;
			endcase
		end
	end

	logic valid_out_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_s <= 1'b0;
			out_data    <= '0;
		end else if (advance) begin
			valid_out_s <= fin.valid;
			out_data    <= res;
		end
	end

	assign out_valid = valid_out_s;

	// checks
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |-> out_data.result_value == '0)
		else $error("divide by zero result not zero");

	a_dz_op: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid && fin.dz |-> (fin.op == OP_DIV || fin.op == OP_MOD))
		else $error("divide by zero flag on non-divide opcode");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fin))
		else $error("pipeline moved while output stalled");

endmodule
